FILE: src/ppp_pkg.sv
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared types and constants for the procedural pattern pixel core.
// ----------------------------------------------------------------------------
package ppp_pkg;

  localparam int unsigned NOISE_SIDE = 256;
  localparam int unsigned DISC_SIDE  = 64;
  localparam int unsigned NOISE_BITS = $clog2(NOISE_SIDE);
  localparam int unsigned DISC_BITS  = $clog2(DISC_SIDE);

  localparam int unsigned COORD_W = 8;
  localparam int unsigned Q_BITS  = 24;
  localparam int unsigned FRAC_W  = Q_BITS + 1;
  localparam logic [FRAC_W-1:0] Q_ONE = FRAC_W'(1) << Q_BITS;

  // datapath register stages ahead of the output register
  localparam int unsigned DEPTH = 10;

  localparam int unsigned SIDE_W = 9;
  localparam logic [SIDE_W-1:0] SIDE_WHITE = SIDE_W'(1);
  localparam logic [SIDE_W-1:0] SIDE_DISC  = SIDE_W'(DISC_SIDE);
  localparam logic [SIDE_W-1:0] SIDE_NOISE = SIDE_W'(NOISE_SIDE);

  typedef enum logic [1:0] {
    PAT_WHITE = 2'd0,
    PAT_DISC  = 2'd1,
    PAT_NOISE = 2'd2
  } pattern_e;

  typedef logic [DEPTH-1:0] stage_en_t;

endpackage

FILE: src/ppp_disc.sv
// ----------------------------------------------------------------------------
// ppp_disc
// Radial disc falloff: squared radius, pipelined square root, squared falloff.
// ----------------------------------------------------------------------------
module ppp_disc (
  input  logic                                clk_i,
  input  ppp_pkg::stage_en_t                  en_i,
  input  logic [ppp_pkg::COORD_W-1:0]         x_i,
  input  logic [ppp_pkg::COORD_W-1:0]         y_i,
  output logic [ppp_pkg::FRAC_W-1:0]          frac_o
);

  localparam int unsigned MAG_W   = ppp_pkg::DISC_BITS + 1;
  localparam int unsigned SQ_W    = 2 * MAG_W + 1;
  localparam int unsigned RAD_W   = 2 * ppp_pkg::Q_BITS;
  localparam int unsigned ROOT_W  = ppp_pkg::Q_BITS;
  localparam int unsigned REM_W   = ROOT_W + 2;
  localparam int unsigned PER_STG = 3;
  localparam int unsigned SQ_STGS = ROOT_W / PER_STG;
  localparam int unsigned NN      = ppp_pkg::DISC_SIDE * ppp_pkg::DISC_SIDE;
  localparam int unsigned RAD_SH  = RAD_W - 2 * ppp_pkg::DISC_BITS;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic              in_disc;
  } sqrt_t;

  function automatic logic [MAG_W-1:0] dist_mag(logic [ppp_pkg::DISC_BITS-1:0] a);
    logic [MAG_W-1:0] odd;
    logic [MAG_W-1:0] side;
    odd  = {a, 1'b1};
    side = MAG_W'(ppp_pkg::DISC_SIDE);
    if (odd >= side) begin
      return odd - side;
    end
    return side - odd;
  endfunction

  function automatic sqrt_t sqrt_steps(sqrt_t st);
    sqrt_t            r;
    logic [REM_W:0]   rem2;
    logic [REM_W:0]   trial;
    r = st;
    for (int i = 0; i < PER_STG; i++) begin
      rem2  = {r.rem[REM_W-2:0], r.rad[RAD_W-1 -: 2]};
      trial = {1'b0, r.root, 2'b01};
      r.rad = {r.rad[RAD_W-3:0], 2'b00};
      if (rem2 >= trial) begin
        r.rem  = REM_W'(rem2 - trial);
        r.root = {r.root[ROOT_W-2:0], 1'b1};
      end else begin
        r.rem  = REM_W'(rem2);
        r.root = {r.root[ROOT_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  logic [MAG_W-1:0] ux, uy;
  logic [SQ_W-1:0]  s_sum;
  sqrt_t            sq_q [SQ_STGS+1];
  logic [ppp_pkg::FRAC_W-1:0] fall;
  logic [2*ppp_pkg::FRAC_W-1:0] fall_sq;
  logic [ppp_pkg::FRAC_W-1:0] frac_q;

  always_comb begin
    ux    = dist_mag(x_i[ppp_pkg::DISC_BITS-1:0]);
    uy    = dist_mag(y_i[ppp_pkg::DISC_BITS-1:0]);
    s_sum = SQ_W'(ux) * SQ_W'(ux) + SQ_W'(uy) * SQ_W'(uy);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sq_q[0].rad     <= RAD_W'(s_sum) << RAD_SH;
      sq_q[0].rem     <= '0;
      sq_q[0].root    <= '0;
      sq_q[0].in_disc <= (s_sum < SQ_W'(NN));
    end
    for (int g = 0; g < SQ_STGS; g++) begin
      if (en_i[g+1]) begin
        sq_q[g+1] <= sqrt_steps(sq_q[g]);
      end
    end
  end

  always_comb begin
    fall    = ppp_pkg::Q_ONE - ppp_pkg::FRAC_W'(sq_q[SQ_STGS].root);
    fall_sq = (2*ppp_pkg::FRAC_W)'(fall) * (2*ppp_pkg::FRAC_W)'(fall);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[SQ_STGS+1]) begin
      frac_q <= sq_q[SQ_STGS].in_disc ?
                fall_sq[ppp_pkg::Q_BITS +: ppp_pkg::FRAC_W] : '0;
    end
  end

  assign frac_o = frac_q;

endmodule

FILE: src/ppp_noise.sv
// ----------------------------------------------------------------------------
// ppp_noise
// Three-octave hashed value noise with smoothstep bilinear blending.
// ----------------------------------------------------------------------------
module ppp_noise (
  input  logic                                clk_i,
  input  ppp_pkg::stage_en_t                  en_i,
  input  logic [ppp_pkg::COORD_W-1:0]         x_i,
  input  logic [ppp_pkg::COORD_W-1:0]         y_i,
  output logic [ppp_pkg::FRAC_W-1:0]          frac_o
);

  localparam int unsigned NUM_OCT = 3;
  localparam int unsigned QB      = ppp_pkg::Q_BITS;
  localparam int unsigned FW      = ppp_pkg::FRAC_W;
  localparam int unsigned NB      = ppp_pkg::NOISE_BITS;
  localparam int unsigned ACC_W   = FW + 2;
  localparam int unsigned N_DLY   = ppp_pkg::DEPTH - 7;
  localparam logic [31:0] HASH_X  = 32'd1664525;
  localparam logic [31:0] HASH_Y  = 32'd22695477;
  localparam logic [31:0] HASH_O  = 32'd2654435761;
  localparam logic [31:0] HASH_M  = 32'd2246822519;
  localparam logic [QB-1:0] AMP_FIRST = QB'(9227468);
  localparam logic [QB-1:0] LAT_MAX   = '1;

  function automatic logic [31:0] pre_hash(logic [NB-1:0] gx, logic [NB-1:0] gy,
                                           logic [31:0] oc);
    logic [31:0] v;
    v = (32'(gx) * HASH_X) ^ (32'(gy) * HASH_Y) ^ oc;
    return v ^ (v >> 16);
  endfunction

  function automatic logic [FW-1:0] blend(logic [FW-1:0] a, logic [FW-1:0] b,
                                          logic [FW-1:0] t);
    logic [FW-1:0]   diff;
    logic [2*FW-1:0] p;
    diff = (b >= a) ? b - a : a - b;
    p    = (2*FW)'(t) * (2*FW)'(diff);
    return (b >= a) ? a + p[QB +: FW] : a - p[QB +: FW];
  endfunction

  logic [NB-1:0] px, py;
  assign px = NB'(x_i);
  assign py = NB'(y_i);

  logic [31:0]   h_d   [NUM_OCT][4];
  logic [QB-1:0] fx_d  [NUM_OCT];
  logic [QB-1:0] fy_d  [NUM_OCT];

  logic [31:0]   h_q   [NUM_OCT][4];
  logic [QB-1:0] fx0_q [NUM_OCT];
  logic [QB-1:0] fy0_q [NUM_OCT];
  logic [31:0]   hm_q  [NUM_OCT][4];
  logic [QB-1:0] sqx_q [NUM_OCT];
  logic [QB-1:0] sqy_q [NUM_OCT];
  logic [QB-1:0] fx1_q [NUM_OCT];
  logic [QB-1:0] fy1_q [NUM_OCT];
  logic [FW-1:0] lat_q [NUM_OCT][4];
  logic [FW-1:0] smx_q [NUM_OCT];
  logic [FW-1:0] smy_q [NUM_OCT];
  logic [FW-1:0] ab_q  [NUM_OCT];
  logic [FW-1:0] cd_q  [NUM_OCT];
  logic [FW-1:0] smy3_q[NUM_OCT];
  logic [FW-1:0] v_q   [NUM_OCT];
  logic [FW-1:0] term_q[NUM_OCT];
  logic [FW-1:0] acc_q;
  logic [FW-1:0] dly_q [N_DLY];

  // cell coordinates, fractions and the first hash round
  always_comb begin
    int unsigned   sh;
    logic [NB-1:0] cmask;
    logic [NB-1:0] sx, sy, gx0, gx1, gy0, gy1;
    logic [NB-1:0] fmask;
    logic [31:0]   oc;
    for (int o = 0; o < NUM_OCT; o++) begin
      sh    = NB - 3 - o;
      cmask = NB'((8 << o) - 1);
      fmask = NB'((1 << sh) - 1);
      sx    = px >> sh;
      sy    = py >> sh;
      gx0   = sx & cmask;
      gy0   = sy & cmask;
      gx1   = NB'(sx + 1'b1) & cmask;
      gy1   = NB'(sy + 1'b1) & cmask;
      fx_d[o] = QB'(32'(px & fmask) << (QB - sh));
      fy_d[o] = QB'(32'(py & fmask) << (QB - sh));
      oc      = HASH_O * 32'(o);
      h_d[o][0] = pre_hash(gx0, gy0, oc);
      h_d[o][1] = pre_hash(gx1, gy0, oc);
      h_d[o][2] = pre_hash(gx0, gy1, oc);
      h_d[o][3] = pre_hash(gx1, gy1, oc);
    end
  end

  always_ff @(posedge clk_i) begin
    logic [31:0]     v;
    logic [2*QB-1:0] sq;
    logic [QB+1:0]   k;
    logic [2*FW-1:0] sm;
    logic [2*FW-1:0] tp;
    logic [ACC_W-1:0] sum;
    for (int o = 0; o < NUM_OCT; o++) begin
      if (en_i[0]) begin
        for (int c = 0; c < 4; c++) begin
          h_q[o][c] <= h_d[o][c];
        end
        fx0_q[o] <= fx_d[o];
        fy0_q[o] <= fy_d[o];
      end
      if (en_i[1]) begin
        for (int c = 0; c < 4; c++) begin
          hm_q[o][c] <= h_q[o][c] * HASH_M;
        end
        sq       = (2*QB)'(fx0_q[o]) * (2*QB)'(fx0_q[o]);
        sqx_q[o] <= sq[QB +: QB];
        sq       = (2*QB)'(fy0_q[o]) * (2*QB)'(fy0_q[o]);
        sqy_q[o] <= sq[QB +: QB];
        fx1_q[o] <= fx0_q[o];
        fy1_q[o] <= fy0_q[o];
      end
      if (en_i[2]) begin
        for (int c = 0; c < 4; c++) begin
          v = hm_q[o][c] ^ (hm_q[o][c] >> 13);
          lat_q[o][c] <= (v[QB-1:0] == LAT_MAX) ? ppp_pkg::Q_ONE : FW'(v[QB-1:0]);
        end
        k        = (QB+2)'(3) * (QB+2)'(ppp_pkg::Q_ONE) - {1'b0, fx1_q[o], 1'b0};
        sm       = (2*FW)'(sqx_q[o]) * (2*FW)'(k);
        smx_q[o] <= sm[QB +: FW];
        k        = (QB+2)'(3) * (QB+2)'(ppp_pkg::Q_ONE) - {1'b0, fy1_q[o], 1'b0};
        sm       = (2*FW)'(sqy_q[o]) * (2*FW)'(k);
        smy_q[o] <= sm[QB +: FW];
      end
      if (en_i[3]) begin
        ab_q[o]   <= blend(lat_q[o][0], lat_q[o][1], smx_q[o]);
        cd_q[o]   <= blend(lat_q[o][2], lat_q[o][3], smx_q[o]);
        smy3_q[o] <= smy_q[o];
      end
      if (en_i[4]) begin
        v_q[o] <= blend(ab_q[o], cd_q[o], smy3_q[o]);
      end
      if (en_i[5]) begin
        tp        = (2*FW)'(AMP_FIRST >> o) * (2*FW)'(v_q[o]);
        term_q[o] <= tp[QB +: FW];
      end
    end
    if (en_i[6]) begin
      sum = '0;
      for (int o = 0; o < NUM_OCT; o++) begin
        sum = sum + ACC_W'(term_q[o]);
      end
      acc_q <= (sum > ACC_W'(ppp_pkg::Q_ONE)) ? ppp_pkg::Q_ONE : FW'(sum);
    end
    for (int d = 0; d < N_DLY; d++) begin
      if (en_i[7+d]) begin
        dly_q[d] <= (d == 0) ? acc_q : dly_q[(d == 0) ? 0 : d-1];
      end
    end
  end

  assign frac_o = dly_q[N_DLY-1];

endmodule

FILE: src/procedural_pattern_pixel_core.sv
// ----------------------------------------------------------------------------
// procedural_pattern_pixel_core
// Pixel generator for solid white, radial disc and value noise patterns.
// ----------------------------------------------------------------------------
// One request per clock cycle is accepted while in_stall_o is low, and each
// yields one pixel after ten datapath stages, the first of which captures
// the request, and then through the output register. The depth is
// set by the disc path's square root, which resolves three result bits per
// stage. Every stage holds its own valid bit, so empty stages fill while the
// output is stalled and the input stalls only when the whole pipeline is full.
module procedural_pattern_pixel_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      pattern_i,
  input  logic [ppp_pkg::COORD_W-1:0]     pixel_x_i,
  input  logic [ppp_pkg::COORD_W-1:0]     pixel_y_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      gray_level_o,
  output logic [7:0]                      alpha_level_o,
  output logic [ppp_pkg::SIDE_W-1:0]      pattern_side_o
);

  localparam int unsigned D = ppp_pkg::DEPTH;

  logic [D:0]                 vld_q;
  logic [D:0]                 ready;
  ppp_pkg::pattern_e          pat_q [D];
  ppp_pkg::stage_en_t         en;
  logic [ppp_pkg::FRAC_W-1:0] disc_frac, noise_frac, frac;
  logic [ppp_pkg::FRAC_W+7:0] scaled;
  logic [7:0]                 level;
  logic [7:0]                 gray_d, alpha_d;
  logic [ppp_pkg::SIDE_W-1:0] side_d;
  logic [7:0]                 gray_q, alpha_q;
  logic [ppp_pkg::SIDE_W-1:0] side_q;

  always_comb begin
    ready[D] = !vld_q[D] || !out_stall_i;
    for (int k = D - 1; k >= 0; k--) begin
      ready[k] = !vld_q[k] || ready[k+1];
    end
  end

  assign en         = ready[D-1:0];
  assign in_stall_o = !ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (ready[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k <= D; k++) begin
        if (ready[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready[0]) begin
      pat_q[0] <= ppp_pkg::pattern_e'(pattern_i);
    end
    for (int k = 1; k < D; k++) begin
      if (ready[k]) begin
        pat_q[k] <= pat_q[k-1];
      end
    end
  end

  ppp_disc u_disc (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (pixel_x_i),
    .y_i    (pixel_y_i),
    .frac_o (disc_frac)
  );

  ppp_noise u_noise (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (pixel_x_i),
    .y_i    (pixel_y_i),
    .frac_o (noise_frac)
  );

  // scale by 255 and pick the channel layout
  always_comb begin
    frac   = (pat_q[D-1] == ppp_pkg::PAT_DISC) ? disc_frac : noise_frac;
    scaled = ((ppp_pkg::FRAC_W+8)'(frac) << 8) - (ppp_pkg::FRAC_W+8)'(frac);
    level  = scaled[ppp_pkg::Q_BITS +: 8];
    unique case (pat_q[D-1])
      ppp_pkg::PAT_WHITE: begin
        gray_d  = 8'hFF;
        alpha_d = 8'hFF;
        side_d  = ppp_pkg::SIDE_WHITE;
      end
      ppp_pkg::PAT_DISC: begin
        gray_d  = 8'hFF;
        alpha_d = level;
        side_d  = ppp_pkg::SIDE_DISC;
      end
      default: begin
        gray_d  = level;
        alpha_d = 8'hFF;
        side_d  = ppp_pkg::SIDE_NOISE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ready[D]) begin
      gray_q  <= gray_d;
      alpha_q <= alpha_d;
      side_q  <= side_d;
    end
  end

  assign out_valid_o    = vld_q[D];
  assign gray_level_o   = gray_q;
  assign alpha_level_o  = alpha_q;
  assign pattern_side_o = side_q;

`ifndef SYNTH
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vld_q))
    else $error("input stalled with an empty stage");

  a_bubble_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!vld_q[D-1] && ready[D]) |=> !out_valid_o)
    else $error("output valid without a request behind it");

  a_disc_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && pattern_side_o == ppp_pkg::SIDE_DISC) |-> (gray_level_o == 8'hFF))
    else $error("disc pixel with gray below full");
`endif

endmodule

FILE: bench/procedural_pattern_pixel_core_tb.sv
// ----------------------------------------------------------------------------
// procedural_pattern_pixel_core_tb
// Self-checking bench for the pattern pixel core: white, disc and noise
// requests go in, mostly with random gaps, a predictor computes each pixel, and a
// checker compares every returned pixel with the oldest prediction.
// ----------------------------------------------------------------------------
module procedural_pattern_pixel_core_tb;

  typedef struct packed {
    logic [7:0]                 gray;
    logic [7:0]                 alpha;
    logic [ppp_pkg::SIDE_W-1:0] side;
  } pixel_t;

  localparam int unsigned STALL_LIMIT = 2000;
  // spare pattern code, handled like noise
  localparam logic [1:0] PAT_SPARE = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] pattern_i = '0;
  logic [ppp_pkg::COORD_W-1:0] pixel_x_i = '0;
  logic [ppp_pkg::COORD_W-1:0] pixel_y_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [7:0] gray_level_o;
  logic [7:0] alpha_level_o;
  logic [ppp_pkg::SIDE_W-1:0] pattern_side_o;

  pixel_t pending_pixels[$];
  int errors = 0;
  int idle_cycles = 0;
  bit sink_idle_on = 1'b1;
  bit sink_hold = 1'b0;
  bit src_idle_on = 1'b1;

  always #6 clk_i = ~clk_i;

  procedural_pattern_pixel_core dut (.*);

  function automatic logic [31:0] isqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res[31:0];
  endfunction

  function automatic logic [31:0] lattice(logic [31:0] gx, logic [31:0] gy, logic [31:0] oct);
    logic [31:0] v;
    v = (gx * 32'd1664525) ^ (gy * 32'd22695477) ^ (oct * 32'd2654435761);
    v ^= v >> 16;
    v = v * 32'd2246822519;
    v ^= v >> 13;
    v &= 32'hFFFFFF;
    return (v == 32'hFFFFFF) ? 32'(ppp_pkg::Q_ONE) : v;
  endfunction

  function automatic logic [31:0] smoothstep(logic [31:0] f);
    logic [63:0] sq, k, p;
    sq = (64'(f) * 64'(f)) >> 24;
    k = 3 * 64'(ppp_pkg::Q_ONE) - 2 * 64'(f);
    p = (sq * k) >> 24;
    return p[31:0];
  endfunction

  function automatic logic [31:0] lerp(logic [31:0] a, logic [31:0] b, logic [31:0] t);
    logic [63:0] p;
    if (b >= a) begin
      p = (64'(t) * 64'(b - a)) >> 24;
      return a + p[31:0];
    end
    p = (64'(t) * 64'(a - b)) >> 24;
    return a - p[31:0];
  endfunction

  function automatic pixel_t predict_pixel(logic [1:0] pat, logic [7:0] x, logic [7:0] y);
    pixel_t px;
    logic signed [31:0] ux, uy;
    logic [63:0] s, nn, fall, f2, acc, tmp;
    logic [31:0] r, amp, cells, stp, cx, cy, fx, fy, a, b, c, d, v, xm, ym;
    if (pat == ppp_pkg::PAT_WHITE) begin
      px = '{8'd255, 8'd255, ppp_pkg::SIDE_WHITE};
    end else if (pat == ppp_pkg::PAT_DISC) begin
      ux = 2 * int'(x % ppp_pkg::DISC_SIDE) + 1 - int'(ppp_pkg::DISC_SIDE);
      uy = 2 * int'(y % ppp_pkg::DISC_SIDE) + 1 - int'(ppp_pkg::DISC_SIDE);
      s = 64'(ux * ux + uy * uy);
      nn = 64'(ppp_pkg::DISC_SIDE) * ppp_pkg::DISC_SIDE;
      px = '{8'd255, 8'd0, ppp_pkg::SIDE_DISC};
      if (s < nn) begin
        r = isqrt((s << 48) / nn);
        fall = 64'(ppp_pkg::Q_ONE) - r;
        f2 = (fall * fall) >> 24;
        tmp = (f2 * 255) >> 24;
        px.alpha = tmp[7:0];
      end
    end else begin
      xm = x % ppp_pkg::NOISE_SIDE;
      ym = y % ppp_pkg::NOISE_SIDE;
      acc = 0;
      amp = 32'd9227468;
      for (int o = 0; o < 3; o++) begin
        cells = 32'd8 << o;
        stp = ppp_pkg::NOISE_SIDE / cells;
        if (stp == 0) stp = 1;
        cx = xm / stp;
        cy = ym / stp;
        tmp = (64'(xm % stp) << 24) / stp;
        fx = smoothstep(tmp[31:0]);
        tmp = (64'(ym % stp) << 24) / stp;
        fy = smoothstep(tmp[31:0]);
        a = lattice(cx % cells, cy % cells, o);
        b = lattice((cx + 1) % cells, cy % cells, o);
        c = lattice(cx % cells, (cy + 1) % cells, o);
        d = lattice((cx + 1) % cells, (cy + 1) % cells, o);
        v = lerp(lerp(a, b, fx), lerp(c, d, fx), fy);
        acc += (64'(amp) * v) >> 24;
        amp >>= 1;
      end
      if (acc > 64'(ppp_pkg::Q_ONE)) acc = 64'(ppp_pkg::Q_ONE);
      tmp = (acc * 255) >> 24;
      px = '{tmp[7:0], 8'd255, ppp_pkg::SIDE_NOISE};
    end
    return px;
  endfunction

  task automatic send_request(logic [1:0] pat, logic [7:0] x, logic [7:0] y);
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pattern_i <= pat;
    pixel_x_i <= x;
    pixel_y_i <= y;
    pending_pixels.insert(pending_pixels.size(), predict_pixel(pat, x, y));
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_request(ppp_pkg::PAT_WHITE, 8'h00, 8'h00);
    send_request(ppp_pkg::PAT_WHITE, 8'hFF, 8'hFF);
    send_request(ppp_pkg::PAT_DISC, 8'd0, 8'd0);
    send_request(ppp_pkg::PAT_DISC, 8'd63, 8'd63);
    send_request(ppp_pkg::PAT_DISC, 8'd31, 8'd32);
    send_request(ppp_pkg::PAT_DISC, 8'd32, 8'd32);
    send_request(ppp_pkg::PAT_DISC, 8'd96, 8'd160);
    send_request(ppp_pkg::PAT_DISC, 8'd255, 8'd0);
    send_request(ppp_pkg::PAT_DISC, 8'd0, 8'd40);
    send_request(ppp_pkg::PAT_NOISE, 8'd0, 8'd0);
    send_request(ppp_pkg::PAT_NOISE, 8'd255, 8'd255);
    send_request(ppp_pkg::PAT_NOISE, 8'd31, 8'd224);
    send_request(ppp_pkg::PAT_NOISE, 8'd128, 8'd7);
    send_request(PAT_SPARE, 8'd0, 8'd0);
    send_request(PAT_SPARE, 8'd255, 8'd17);
    send_request(PAT_SPARE, 8'd170, 8'd85);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++)
      send_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
  endtask

  task automatic test_backpressure();
    sink_hold = 1'b1;
    test_random(40);
    sink_hold = 1'b0;
    drain();
    test_random(20);
  endtask

  task automatic test_full_rate();
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    test_random(300);
  endtask

  // sink side stall pattern
  initial begin
    int hold_cnt;
    @(posedge rst_ni);
    forever begin
      if (sink_hold) begin
        out_stall_i <= 1'b1;
        hold_cnt = 0;
        while (sink_hold && hold_cnt < 60) begin
          @(posedge clk_i);
          hold_cnt++;
        end
        out_stall_i <= 1'b0;
        do @(posedge clk_i); while (sink_hold);
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    pixel_t exp_px;
    if (out_valid_o && !out_stall_i) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel gray=%0d alpha=%0d side=%0d",
               gray_level_o, alpha_level_o, pattern_side_o);
        errors++;
      end else begin
        exp_px = pending_pixels.pop_front();
        if (gray_level_o !== exp_px.gray) begin
          $error("gray_level expected %0d actual %0d", exp_px.gray, gray_level_o);
          errors++;
        end
        if (alpha_level_o !== exp_px.alpha) begin
          $error("alpha_level expected %0d actual %0d", exp_px.alpha, alpha_level_o);
          errors++;
        end
        if (pattern_side_o !== exp_px.side) begin
          $error("pattern_side expected %0d actual %0d", exp_px.side, pattern_side_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("procedural_pattern_pixel_core_tb: errors");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(1200);
    test_backpressure();
    drain();
    test_random(300);
    test_full_rate();
    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("procedural_pattern_pixel_core_tb: clean");
    else $display("procedural_pattern_pixel_core_tb: errors");
    $finish;
  end

endmodule

FILE: procedural_pattern_pixel_core.f
src/ppp_pkg.sv
src/ppp_disc.sv
src/ppp_noise.sv
src/procedural_pattern_pixel_core.sv
bench/procedural_pattern_pixel_core_tb.sv
